// File: hdl/rnlt_pkg.sv
// shared types and constants for the rtp nack loss tracker
package rnlt_pkg;

  localparam int TRACK_DEPTH = 64;
  localparam int IDX_W       = $clog2(TRACK_DEPTH);
  localparam int CNT_W       = $clog2(TRACK_DEPTH + 1);
  localparam int SEQ_W       = 16;
  localparam int TIME_W      = 48;
  localparam int RETRY_W     = 3;
  localparam int LIMIT_W     = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int KIND_W      = 2;
  localparam int MAXC_W      = 7;

  localparam logic [KIND_W-1:0] KIND_PACKET  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POLL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEANUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_IVL   = 2'd2;

  localparam logic [LIMIT_W-1:0] MAX_AGE_RST     = 24'd1000000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 3'd3;
  localparam logic [LIMIT_W-1:0] RETRY_IVL_RST   = 24'd100000;

  localparam logic [SEQ_W-1:0] HALF_SEQ = 16'd32768;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  first_time;
    logic [TIME_W-1:0]  last_time;
    logic [RETRY_W-1:0] retries;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ADD,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIRST,
    OP_DROP,
    OP_ADD,
    OP_POLL,
    OP_CLEAN
  } op_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic add_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op_in;
    op_t  op;
    logic scan_done;
    logic add_done;
  } dp_stat_t;

endpackage

// File: hdl/rnlt_ram.sv
// generic single write port ram with registered read
module rnlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rnlt_ctrl.sv
// sequencer for the table walks
module rnlt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rnlt_pkg::dp_stat_t stat,
  output rnlt_pkg::ctrl_cmd_t cmd
);

  rnlt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rnlt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rnlt_pkg::ST_IDLE: begin
        if (start) begin
          if (stat.op_in == rnlt_pkg::OP_FIRST || stat.op_in == rnlt_pkg::OP_NONE) begin
            state_nxt = rnlt_pkg::ST_FINISH;
          end else begin
            state_nxt = rnlt_pkg::ST_READ;
          end
        end
      end
      rnlt_pkg::ST_READ: begin
        if (stat.scan_done) begin
          state_nxt = (stat.op == rnlt_pkg::OP_ADD) ? rnlt_pkg::ST_ADD : rnlt_pkg::ST_FINISH;
        end else begin
          state_nxt = rnlt_pkg::ST_EVAL;
        end
      end
      rnlt_pkg::ST_EVAL:   state_nxt = rnlt_pkg::ST_READ;
      rnlt_pkg::ST_ADD: begin
        if (stat.add_done) begin
          state_nxt = rnlt_pkg::ST_FINISH;
        end
      end
      rnlt_pkg::ST_FINISH: state_nxt = rnlt_pkg::ST_IDLE;
      default:             state_nxt = rnlt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != rnlt_pkg::ST_IDLE);
    case (state_r)
      rnlt_pkg::ST_IDLE:   cmd.latch    = start;
      rnlt_pkg::ST_EVAL:   cmd.eval     = 1'b1;
      rnlt_pkg::ST_ADD:    cmd.add_step = !stat.add_done;
      rnlt_pkg::ST_FINISH: cmd.finish   = 1'b1;
      default:             cmd          = '0;
    endcase
  end

endmodule

// File: hdl/rnlt_dp.sv
// table storage, walk counters, eligibility checks and result register
module rnlt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rnlt_pkg::ctrl_cmd_t              cmd,
  output rnlt_pkg::dp_stat_t               stat,
  input  logic [rnlt_pkg::KIND_W-1:0]      in_kind,
  input  logic [rnlt_pkg::SEQ_W-1:0]       in_seq,
  input  logic [rnlt_pkg::TIME_W-1:0]      in_now,
  input  logic [rnlt_pkg::MAXC_W-1:0]      in_max_count,
  input  logic                             cfg_we,
  input  logic [rnlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rnlt_pkg::LIMIT_W-1:0]     cfg_data,
  output logic                             out_valid,
  output logic [rnlt_pkg::SEQ_W-1:0]       out_nack_seq,
  output logic                             out_seq_valid,
  output logic                             out_last,
  output logic [rnlt_pkg::CNT_W-1:0]       out_tracked_count
);

  localparam int IW = rnlt_pkg::IDX_W;
  localparam int CW = rnlt_pkg::CNT_W;
  localparam int SW = rnlt_pkg::SEQ_W;
  localparam int TW = rnlt_pkg::TIME_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(rnlt_pkg::TRACK_DEPTH);

  // configuration
  logic [rnlt_pkg::LIMIT_W-1:0] max_age_r, retry_ivl_r;
  logic [rnlt_pkg::RETRY_W-1:0] max_retries_r;

  // persistent tracker state
  logic          started_r;
  logic [SW-1:0] highest_r;
  logic [CW-1:0] count_r;

  // per item working state
  rnlt_pkg::op_t       op_r;
  logic [SW-1:0]       seq_r;
  logic [TW-1:0]       now_r;
  logic [rnlt_pkg::MAXC_W-1:0] maxc_r;
  logic [CW-1:0]       i_r, j_r, add_r, tries_r, emit_r;
  logic [SW-1:0]       expected_r;
  logic                found_r;
  logic [rnlt_pkg::TRACK_DEPTH-1:0] seen_r;
  logic                pend_vld_r;
  logic [SW-1:0]       pend_seq_r;

  // ram
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  rnlt_pkg::entry_t     ram_wdata, ram_rdata;
  logic [rnlt_pkg::ENTRY_W-1:0] rdata_raw;

  rnlt_ram #(.WIDTH(rnlt_pkg::ENTRY_W), .DEPTH(rnlt_pkg::TRACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (i_r[IW-1:0]),
    .rdata (rdata_raw)
  );
  assign ram_rdata = rnlt_pkg::entry_t'(rdata_raw);

  // op decode on the incoming word
  logic [SW-1:0] d16;
  logic          is_new;
  logic [SW-1:0] gap16;
  logic [CW-1:0] tries_in;
  rnlt_pkg::op_t op_in;

  assign d16    = in_seq - highest_r;
  assign is_new = (d16 != '0) && (d16 <= rnlt_pkg::HALF_SEQ);
  assign gap16  = d16 - SW'(1);
  assign tries_in = (gap16 > SW'(rnlt_pkg::TRACK_DEPTH)) ? DEPTH_C : gap16[CW-1:0];

  always_comb begin
    case (in_kind)
      rnlt_pkg::KIND_PACKET: begin
        if (!started_r)  op_in = rnlt_pkg::OP_FIRST;
        else if (is_new) op_in = rnlt_pkg::OP_ADD;
        else             op_in = rnlt_pkg::OP_DROP;
      end
      rnlt_pkg::KIND_POLL:    op_in = rnlt_pkg::OP_POLL;
      rnlt_pkg::KIND_CLEANUP: op_in = rnlt_pkg::OP_CLEAN;
      default:                op_in = rnlt_pkg::OP_NONE;
    endcase
  end

  // entry checks
  logic [TW-1:0] age, since;
  logic          too_old, out_of_retries, too_soon, eligible, drop_clean, drop_match;
  logic [SW-1:0] off;

  assign age            = now_r - ram_rdata.first_time;
  assign since          = now_r - ram_rdata.last_time;
  assign too_old        = !age[TW-1] && (age > TW'(max_age_r));
  assign out_of_retries = ram_rdata.retries >= max_retries_r;
  assign too_soon       = (ram_rdata.retries != '0) &&
                          (since[TW-1] || (since < TW'(retry_ivl_r)));
  assign eligible       = !too_old && !out_of_retries && !too_soon;
  assign drop_clean     = too_old || out_of_retries;
  assign drop_match     = !found_r && (ram_rdata.seq == seq_r);
  assign off            = ram_rdata.seq - expected_r;

  logic scan_done, add_done, can_add;
  assign scan_done = (i_r == count_r) ||
                     ((op_r == rnlt_pkg::OP_POLL) && (emit_r == maxc_r));
  assign add_done  = (add_r == tries_r);
  assign can_add   = !seen_r[add_r[IW-1:0]] && (count_r < DEPTH_C);

  assign stat.op_in     = op_in;
  assign stat.op        = op_r;
  assign stat.scan_done = scan_done;
  assign stat.add_done  = add_done;

  // ram write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j_r[IW-1:0];
    ram_wdata = ram_rdata;
    if (cmd.eval) begin
      case (op_r)
        rnlt_pkg::OP_DROP:  ram_we = !drop_match;
        rnlt_pkg::OP_CLEAN: ram_we = !drop_clean;
        rnlt_pkg::OP_POLL: begin
          ram_we              = eligible;
          ram_waddr           = i_r[IW-1:0];
          ram_wdata.last_time = now_r;
          ram_wdata.retries   = ram_rdata.retries + 1'b1;
        end
        default: ram_we = 1'b0;
      endcase
    end else if (cmd.add_step) begin
      ram_we               = can_add;
      ram_waddr            = count_r[IW-1:0];
      ram_wdata.seq        = expected_r + SW'(add_r);
      ram_wdata.first_time = now_r;
      ram_wdata.last_time  = '0;
      ram_wdata.retries    = '0;
    end
  end

  logic [CW-1:0] final_cnt;
  assign final_cnt = (op_r == rnlt_pkg::OP_DROP || op_r == rnlt_pkg::OP_CLEAN) ? j_r : count_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r     <= rnlt_pkg::MAX_AGE_RST;
      max_retries_r <= rnlt_pkg::MAX_RETRIES_RST;
      retry_ivl_r   <= rnlt_pkg::RETRY_IVL_RST;
      started_r     <= 1'b0;
      highest_r     <= '0;
      count_r       <= '0;
      out_valid     <= 1'b0;
      op_r          <= rnlt_pkg::OP_NONE;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rnlt_pkg::REG_MAX_AGE:     max_age_r     <= cfg_data;
          rnlt_pkg::REG_MAX_RETRIES: max_retries_r <= cfg_data[rnlt_pkg::RETRY_W-1:0];
          rnlt_pkg::REG_RETRY_IVL:   retry_ivl_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.latch) begin
        op_r <= op_in;
        if (op_in == rnlt_pkg::OP_FIRST) begin
          started_r <= 1'b1;
          highest_r <= in_seq;
        end else if (op_in == rnlt_pkg::OP_ADD) begin
          highest_r <= in_seq;
        end
      end
      if (cmd.eval && op_r == rnlt_pkg::OP_POLL && eligible && pend_vld_r) begin
        out_valid <= 1'b1;
      end
      if (cmd.add_step && can_add) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.finish) begin
        count_r   <= final_cnt;
        out_valid <= 1'b1;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      seq_r      <= in_seq;
      now_r      <= in_now;
      maxc_r     <= in_max_count;
      expected_r <= highest_r + SW'(1);
      tries_r    <= tries_in;
      i_r        <= '0;
      j_r        <= '0;
      add_r      <= '0;
      emit_r     <= '0;
      found_r    <= 1'b0;
      seen_r     <= '0;
      pend_vld_r <= 1'b0;
    end
    if (cmd.eval) begin
      i_r <= i_r + 1'b1;
      case (op_r)
        rnlt_pkg::OP_DROP: begin
          if (drop_match) found_r <= 1'b1;
          else            j_r     <= j_r + 1'b1;
        end
        rnlt_pkg::OP_CLEAN: begin
          if (!drop_clean) j_r <= j_r + 1'b1;
        end
        rnlt_pkg::OP_ADD: begin
          if (off < SW'(tries_r)) seen_r[off[IW-1:0]] <= 1'b1;
        end
        rnlt_pkg::OP_POLL: begin
          if (eligible) begin
            emit_r     <= emit_r + 1'b1;
            pend_vld_r <= 1'b1;
            pend_seq_r <= ram_rdata.seq;
            if (pend_vld_r) begin
              out_nack_seq      <= pend_seq_r;
              out_seq_valid     <= 1'b1;
              out_last          <= 1'b0;
              out_tracked_count <= count_r;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.add_step) begin
      add_r <= add_r + 1'b1;
    end
    if (cmd.finish) begin
      out_nack_seq      <= pend_vld_r ? pend_seq_r : '0;
      out_seq_valid     <= pend_vld_r;
      out_last          <= 1'b1;
      out_tracked_count <= final_cnt;
    end
  end

endmodule

// File: hdl/rtp_nack_loss_tracker.sv
// rtp nack loss tracker top level
// the word is latched and the table walked entry by entry up to the closing word; a newer
//   packet then tries each skipped number (up to 64); a first packet or unused kind goes
//   straight to the closing word
// one word at a time: the next word is taken as the closing word shows; the single ram read
//   port walks one entry at a time, each read, then evaluated and written back
// results are strobed for one cycle each; the receiver cannot stall
// reset (synchronous, rst_n low): table empty, not started, registers back to defaults
module rtp_nack_loss_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rnlt_pkg::KIND_W-1:0]      in_kind,
  input  logic [rnlt_pkg::SEQ_W-1:0]       in_seq,
  input  logic [rnlt_pkg::TIME_W-1:0]      in_now,
  input  logic [rnlt_pkg::MAXC_W-1:0]      in_max_count,
  input  logic                             cfg_we,
  input  logic [rnlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rnlt_pkg::LIMIT_W-1:0]     cfg_data,
  output logic                             out_valid,
  output logic [rnlt_pkg::SEQ_W-1:0]       out_nack_seq,
  output logic                             out_seq_valid,
  output logic                             out_last,
  output logic [rnlt_pkg::CNT_W-1:0]       out_tracked_count
);

  // command and status between sequencer and datapath
  rnlt_pkg::ctrl_cmd_t cmd;
  rnlt_pkg::dp_stat_t  stat;

  rnlt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // table ram, walk counters and result register
  rnlt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_seq            (in_seq),
    .in_now            (in_now),
    .in_max_count      (in_max_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_nack_seq      (out_nack_seq),
    .out_seq_valid     (out_seq_valid),
    .out_last          (out_last),
    .out_tracked_count (out_tracked_count)
  );

  // an accepted word always makes the block busy next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  // a word without a requested number is always the closing word
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_seq_valid) |-> out_last) else $error("empty word not last");

  // closing word is never directly followed by another word
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid) else $error("word right after last");

  // table never exceeds its depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tracked_count <= rnlt_pkg::CNT_W'(rnlt_pkg::TRACK_DEPTH)))
    else $error("tracked count over depth");

endmodule

// File: tb/tb.sv
// testbench for the rtp nack loss tracker: directed and random words checked against a predictor
`timescale 1ns / 100ps

module tb;
  import rnlt_pkg::*;

  // the one code the package leaves unnamed: it changes nothing
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one expected result word
  typedef struct {
    logic [SEQ_W-1:0] nack_seq;
    logic             seq_valid;
    logic             last;
    logic [CNT_W-1:0] tracked;
  } nack_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [SEQ_W-1:0]     in_seq = '0;
  logic [TIME_W-1:0]    in_now = '0;
  logic [MAXC_W-1:0]    in_max_count = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 out_valid;
  logic [SEQ_W-1:0]     out_nack_seq;
  logic                 out_seq_valid;
  logic                 out_last;
  logic [CNT_W-1:0]     out_tracked_count;

  rtp_nack_loss_tracker u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_seq(in_seq), .in_now(in_now), .in_max_count(in_max_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_nack_seq(out_nack_seq), .out_seq_valid(out_seq_valid),
    .out_last(out_last), .out_tracked_count(out_tracked_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the registers and the loss table
  logic [LIMIT_W-1:0] age_limit;
  logic [RETRY_W-1:0] retry_limit;
  logic [LIMIT_W-1:0] retry_gap;
  logic               seen_first;
  logic [SEQ_W-1:0]   top_seq;
  logic [SEQ_W-1:0]   lost_seq [TRACK_DEPTH];
  logic [TIME_W-1:0]  lost_first [TRACK_DEPTH];
  logic [TIME_W-1:0]  lost_last [TRACK_DEPTH];
  logic [RETRY_W-1:0] lost_tries [TRACK_DEPTH];
  int                 lost_cnt;

  nack_t       nack_q[$];   // results still to come, oldest first
  int          errors = 0;
  int          idle_pct = 0; // chance in a hundred that the sender pauses before a word
  logic [TIME_W-1:0] clock_us = '0;

  task automatic mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // signed 16-bit distance of a from b, in -32768..32768
  function automatic int seq_dist(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d > 32768) d -= 65536;
    else if (d < -32768) d += 65536;
    return d;
  endfunction

  // 48-bit signed age test: positive and above the limit
  function automatic bit is_stale(input logic [TIME_W-1:0] t_now, input logic [TIME_W-1:0] t,
                                  input logic [LIMIT_W-1:0] lim);
    logic [TIME_W-1:0] d;
    d = t_now - t;
    return !d[TIME_W-1] && (d > TIME_W'(lim));
  endfunction

  // negative differences count as too soon
  function automatic bit too_soon(input logic [TIME_W-1:0] t_now, input logic [TIME_W-1:0] t,
                                  input logic [LIMIT_W-1:0] lim);
    logic [TIME_W-1:0] d;
    d = t_now - t;
    return d[TIME_W-1] || (d < TIME_W'(lim));
  endfunction

  function automatic void drop_lost(input int i);
    for (int k = i; k < lost_cnt - 1; k++) begin
      lost_seq[k]   = lost_seq[k+1];
      lost_first[k] = lost_first[k+1];
      lost_last[k]  = lost_last[k+1];
      lost_tries[k] = lost_tries[k+1];
    end
    lost_cnt--;
  endfunction

  function automatic void mark_lost(input logic [SEQ_W-1:0] s, input logic [TIME_W-1:0] t);
    for (int k = 0; k < lost_cnt; k++)
      if (lost_seq[k] == s) return;
    if (lost_cnt < TRACK_DEPTH) begin
      lost_seq[lost_cnt]   = s;
      lost_first[lost_cnt] = t;
      lost_last[lost_cnt]  = '0;
      lost_tries[lost_cnt] = '0;
      lost_cnt++;
    end
  endfunction

  // works out the result words of one accepted word and queues them
  function automatic void predict_nacks(input logic [KIND_W-1:0] kind,
                                        input logic [SEQ_W-1:0] s,
                                        input logic [TIME_W-1:0] t,
                                        input logic [MAXC_W-1:0] maxc);
    nack_t       r;
    nack_t       outs[$];
    logic [SEQ_W-1:0] nxt;
    int          gap;
    int          i;
    if (kind == KIND_PACKET) begin
      if (!seen_first) begin
        top_seq = s;
        seen_first = 1'b1;
      end else if (seq_dist(s, top_seq) <= 0) begin
        // late or repeated packet: it is no longer missing
        for (i = 0; i < lost_cnt; i++)
          if (lost_seq[i] == s) begin
            drop_lost(i);
            break;
          end
      end else begin
        nxt = top_seq + 1'b1;
        gap = seq_dist(s, nxt);
        for (i = 0; i < gap && i < TRACK_DEPTH; i++)
          mark_lost(nxt + SEQ_W'(i), t);
        top_seq = s;
      end
    end else if (kind == KIND_POLL) begin
      for (i = 0; i < lost_cnt && outs.size() < int'(maxc); i++) begin
        if (is_stale(t, lost_first[i], age_limit)) continue;
        if (lost_tries[i] >= retry_limit) continue;
        if (lost_tries[i] != 0 && too_soon(t, lost_last[i], retry_gap)) continue;
        r.nack_seq = lost_seq[i];
        r.seq_valid = 1'b1;
        r.last = 1'b0;
        outs.push_back(r);
        lost_last[i] = t;
        lost_tries[i] = lost_tries[i] + 1'b1;
      end
    end else if (kind == KIND_CLEANUP) begin
      i = 0;
      while (i < lost_cnt) begin
        if (is_stale(t, lost_first[i], age_limit) || lost_tries[i] >= retry_limit)
          drop_lost(i);
        else
          i++;
      end
    end
    if (outs.size() == 0) begin
      r.nack_seq = '0;
      r.seq_valid = 1'b0;
      r.last = 1'b0;
      outs.push_back(r);
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[k]) begin
      outs[k].tracked = CNT_W'(lost_cnt);
      nack_q.push_back(outs[k]);
    end
  endfunction

  // sends one word; start stays high after acceptance so the next word can follow at once
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] s,
                           input logic [TIME_W-1:0] t, input logic [MAXC_W-1:0] maxc);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_seq <= s;
    in_now <= t;
    in_max_count <= maxc;
    do @(posedge clk); while (busy);
    predict_nacks(kind, s, t, maxc);
  endtask

  // drops start and waits until every result is in and the block is idle
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (nack_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_MAX_AGE:     age_limit = val;
      REG_MAX_RETRIES: retry_limit = val[RETRY_W-1:0];
      REG_RETRY_IVL:   retry_gap = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] age, input logic [RETRY_W-1:0] tries,
                            input logic [LIMIT_W-1:0] ivl);
    write_reg(REG_MAX_AGE, age);
    write_reg(REG_MAX_RETRIES, LIMIT_W'(tries));
    write_reg(REG_RETRY_IVL, ivl);
  endtask

  // first packet, a gap, repeated polls and late packets under the reset limits
  task automatic test_gap_and_retry;
    send_word(KIND_PACKET, 16'd100, 48'd0, 7'd0);      // first packet only sets the top
    send_word(KIND_PACKET, 16'd105, 48'd10, 7'd0);     // 101..104 go missing
    send_word(KIND_POLL, 16'd0, 48'd20, 7'd64);
    send_word(KIND_POLL, 16'd0, 48'd30, 7'd64);        // too soon for a second request
    send_word(KIND_PACKET, 16'd102, 48'd40, 7'd0);     // late packet leaves the table
    send_word(KIND_PACKET, 16'd105, 48'd41, 7'd0);     // equal to the top
    send_word(KIND_POLL, 16'd0, 48'd100020, 7'd2);     // retry interval over, count capped
    send_word(KIND_POLL, 16'd0, 48'd100030, 7'd0);     // zero count reports nothing
    send_word(KIND_CLEANUP, 16'd0, 48'd2000000, 7'd0); // everything over age
    drain();
  endtask

  // wrap-around, a half-range jump that fills the table, time extremes
  task automatic test_wrap_and_full;
    send_word(KIND_PACKET, 16'hFFFE, 48'd50, 7'd0);
    send_word(KIND_PACKET, 16'h0002, 48'd60, 7'd0);    // wraps: ffff, 0, 1
    send_word(KIND_PACKET, 16'h9000, 48'd70, 7'd0);    // far behind, counts as old
    send_word(KIND_PACKET, 16'h8002, 48'd80, 7'd0);    // exactly half ahead, table fills
    send_word(KIND_PACKET, 16'h8100, 48'd90, 7'd0);    // full table, nothing added
    send_word(KIND_POLL, 16'd0, 48'hFFFF_FFFF_FFFF, 7'd64); // time before the entries
    send_word(KIND_POLL, 16'd0, 48'hFFFF_FFFF_FFFF, 7'd64);
    send_word(KIND_UNUSED, 16'hFFFF, 48'h8000_0000_0000, 7'h7F);
    send_word(KIND_CLEANUP, 16'd0, 48'h7FFF_FFFF_FFFF, 7'd0);
    drain();
  endtask

  // register extremes: nothing may be requested with zero retries
  task automatic test_limits;
    set_limits(24'd0, 3'd0, 24'd0);
    send_word(KIND_PACKET, 16'h8010, 48'd1000, 7'd0);
    send_word(KIND_POLL, 16'd0, 48'd1000, 7'd64);
    drain();
    set_limits(24'hFFFFFF, 3'd7, 24'hFFFFFF);
    send_word(KIND_POLL, 16'd0, 48'd1000, 7'd64);
    send_word(KIND_POLL, 16'd0, 48'd1001, 7'd64);
    send_word(KIND_CLEANUP, 16'd0, 48'd1002, 7'd0);
    drain();
  endtask

  // mostly in-order packets with small losses and reordering, polls as time runs on
  task automatic test_random_traffic(input int n);
    int r;
    logic [SEQ_W-1:0] s;
    logic [TIME_W-1:0] t;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      clock_us = clock_us + TIME_W'($urandom_range(0, 600));
      t = clock_us;
      if ($urandom_range(99) < 4) t = TIME_W'({$urandom, $urandom});
      if (r < 50) begin
        if (r < 5) s = SEQ_W'($urandom);
        else if (r < 15) s = top_seq - SEQ_W'($urandom_range(0, 8));
        else s = top_seq + SEQ_W'($urandom_range(1, 5));
        send_word(KIND_PACKET, s, t, MAXC_W'($urandom));
      end else if (r < 82) begin
        send_word(KIND_POLL, SEQ_W'($urandom), t, MAXC_W'($urandom_range(0, 64)));
      end else if (r < 97) begin
        send_word(KIND_CLEANUP, SEQ_W'($urandom), t, MAXC_W'($urandom));
      end else begin
        send_word(KIND_UNUSED, SEQ_W'($urandom), t, MAXC_W'($urandom));
      end
    end
    drain();
  endtask

  // result checker: the receiver cannot stall, so every strobe is one word
  always @(posedge clk) begin : check_results
    nack_t e;
    if (rst_n && out_valid) begin
      if (nack_q.size() == 0) begin
        mismatch($sformatf("result with none expected, seq %0d", out_nack_seq));
      end else begin
        e = nack_q.pop_front();
        if (out_nack_seq !== e.nack_seq)
          mismatch($sformatf("nack_seq %0d, expected %0d", out_nack_seq, e.nack_seq));
        if (out_seq_valid !== e.seq_valid)
          mismatch($sformatf("seq_valid %b, expected %b", out_seq_valid, e.seq_valid));
        if (out_last !== e.last)
          mismatch($sformatf("last %b, expected %b", out_last, e.last));
        if (out_tracked_count !== e.tracked)
          mismatch($sformatf("tracked_count %0d, expected %0d", out_tracked_count, e.tracked));
      end
    end
  end

  initial begin
    age_limit = MAX_AGE_RST;
    retry_limit = MAX_RETRIES_RST;
    retry_gap = RETRY_IVL_RST;
    seen_first = 1'b0;
    top_seq = '0;
    lost_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 20;
    test_gap_and_retry();
    test_wrap_and_full();
    test_limits();

    // random traffic: cleanup first so the table starts small
    set_limits(24'd20000, 3'd2, 24'd500);
    send_word(KIND_CLEANUP, 16'd0, 48'hFFFF_0000_0000, 7'd0);
    send_word(KIND_CLEANUP, 16'd0, 48'd0, 7'd0);
    drain();
    clock_us = 48'd0;
    test_random_traffic(25);
    idle_pct = 66;
    set_limits(24'd3000, 3'd7, 24'd0);
    test_random_traffic(25);
    idle_pct = 0;
    set_limits(24'd400000, 3'd1, 24'd200);
    test_random_traffic(25);

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(12 * 2000000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/rnlt_pkg.sv
hdl/rnlt_ram.sv
hdl/rnlt_ctrl.sv
hdl/rnlt_dp.sv
hdl/rtp_nack_loss_tracker.sv
tb/tb.sv
